FILE: design/lsch_pkg.sv
`default_nettype none
package lsch_pkg;

	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_UNBLOCK = 3'd1;
	localparam logic [2:0] OP_TICK    = 3'd2;
	localparam logic [2:0] OP_BLOCK   = 3'd3;
	localparam logic [2:0] OP_EXIT    = 3'd4;

	localparam logic [0:0] CFG_QUANTUM = 1'd0;
	localparam logic [0:0] CFG_SEED    = 1'd1;

	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	// controller to datapath commands
	typedef struct packed {
		logic capture;     // latch op and slot
		logic do_event;    // apply load, unblock, tick or exit bookkeeping
		logic div_start;   // start compensation division
		logic do_block;    // apply block bookkeeping using quotient
		logic raffle_start;// step lfsr unless pool is zero, start modulo
		logic walk_start;  // begin slot walk
		logic walk_step;   // examine one slot
		logic emit;        // drive result strobe
	} lsch_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_sched;    // captured op is tick, block or exit
		logic ignore;      // captured op is dropped without effect
		logic need_raffle; // event requires a raffle
		logic is_block;
		logic div_done;
		logic walk_done;
		logic pool_zero;
	} lsch_sts_t;

endpackage
`default_nettype wire

FILE: design/lottery_scheduler_top.sv
// Lottery scheduler: pulse start with op and task_slot while busy is low. Load
// and unblock keep busy high for one cycle and give no result. Tick, and block
// or exit while a task runs, give one result on next_task/idle marked by done
// for a single cycle, in the first cycle with busy low again; the receiver
// cannot stall and must take it then. A raffle runs lfsr mod pool in the shared
// 32-bit serial divider, then walks the slots; a block first adds a division
// for the compensation tickets. Write config only while busy is low.
`default_nettype none
module lottery_scheduler_top #(
	parameter int unsigned MAX_TASKS   = 16,
	parameter int unsigned TICKET_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  op,
	input  wire logic [3:0]  task_slot,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic [3:0]       next_task,
	output logic             idle
);

	lsch_pkg::lsch_cmd_t cmd;
	lsch_pkg::lsch_sts_t sts;

	lsch_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
	);

	lsch_dp #(.MAX_TASKS(MAX_TASKS), .TICKET_BITS(TICKET_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .task_slot(task_slot),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .valid(done), .next_task(next_task), .idle(idle)
	);

`ifndef ASSERT_OFF
	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> done) else $error("result strobe missing");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_idle_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && idle |-> next_task == 4'd0) else $error("idle with nonzero task");
`endif

endmodule
`default_nettype wire

FILE: design/lsch_ctrl.sv
`default_nettype none
module lsch_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output lsch_pkg::lsch_cmd_t    cmd,
	input  lsch_pkg::lsch_sts_t    sts
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DECODE = 8'b0000_0010,
		ST_DIV    = 8'b0000_0100,
		ST_BLOCK  = 8'b0000_1000,
		ST_RAFFLE = 8'b0001_0000,
		ST_MOD    = 8'b0010_0000,
		ST_WALK   = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.ignore) begin
					state_d = ST_IDLE;
				end else if (!sts.is_sched) begin
					cmd.do_event = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.is_block) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.do_event = 1'b1;
					state_d = sts.need_raffle ? ST_RAFFLE : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.do_block = 1'b1;
					state_d = ST_RAFFLE;
				end
			end
			ST_BLOCK: state_d = ST_RAFFLE;
			ST_RAFFLE: begin
				cmd.raffle_start = 1'b1;
				state_d = sts.pool_zero ? ST_EMIT : ST_MOD;
			end
			ST_MOD: begin
				if (sts.div_done) begin
					cmd.walk_start = 1'b1;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

FILE: design/lsch_div.sv
`default_nettype none
// restoring divider, one quotient bit a cycle
module lsch_div #(
	parameter int unsigned W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  num_q, den_q, quo_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [W:0]    trial;

	assign trial = {rem_q, num_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= CW'(W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			den_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], num_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done      = !run_q && !go;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

FILE: design/lsch_dp.sv
`default_nettype none
module lsch_dp #(
	parameter int unsigned MAX_TASKS   = 16,
	parameter int unsigned TICKET_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [2:0]        op,
	input  wire logic [3:0]        task_slot,
	input  wire logic              cfg_we,
	input  wire logic              cfg_idx,
	input  wire logic [31:0]       cfg_data,
	input  lsch_pkg::lsch_cmd_t    cmd,
	output lsch_pkg::lsch_sts_t    sts,
	output logic                   valid,
	output logic [3:0]             next_task,
	output logic                   idle
);

	localparam int unsigned SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned PW = TICKET_BITS + SW;
	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
	localparam logic [TICKET_BITS-1:0] CAP = '1;

	logic [7:0]  quantum_q;
	logic [31:0] lfsr_q;
	logic [MAX_TASKS-1:0] valid_q, blocked_q;
	logic [TICKET_BITS-1:0] tickets_q [MAX_TASKS];
	logic [PW-1:0]  pool_q;
	logic [7:0]     qcount_q;
	logic [SW-1:0]  run_q;
	logic           run_idle_q;
	logic [2:0]     op_q;
	logic           slot_ok_q;
	logic [SW-1:0]  sidx_q;
	logic [CNT_W-1:0] widx_q;
	logic [PW-1:0]  acc_q, draw_q;
	logic           found_q, out_v_q;

	logic [7:0]  qinc;
	logic [TICKET_BITS-1:0] cur_t, sel_t;
	logic        div_go, div_done;
	logic [31:0] div_a, div_b, div_q, div_r;
	logic [7:0]  rem8;
	logic [31:0] lfsr_next;
	logic [PW:0] acc_n;
	logic [SW-1:0] widx;
	logic [TICKET_BITS:0] tsum;

	assign qinc  = qcount_q + 8'd1;
	assign cur_t = tickets_q[run_q];
	assign sel_t = tickets_q[sidx_q];
	assign rem8  = quantum_q - qinc;
	assign lfsr_next = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? lsch_pkg::LFSR_TAPS : 32'd0);
	assign widx  = widx_q[SW-1:0];
	assign acc_n = {1'b0, acc_q} + {{(PW+1-TICKET_BITS){1'b0}}, tickets_q[widx]};

	// ceil(q/rem) = (q + rem - 1) / rem; modulo shares the unit
	assign div_go = cmd.div_start || cmd.raffle_start;
	assign div_a = cmd.raffle_start ? lfsr_next
		: 32'({1'b0, quantum_q} + {1'b0, rem8} - 9'd1);
	assign div_b = cmd.raffle_start ? 32'(pool_q) : {24'd0, rem8};

	lsch_div #(.W(32)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
	);

	always_comb begin
		sts = '0;
		sts.is_sched = (op_q == lsch_pkg::OP_TICK) || (op_q == lsch_pkg::OP_BLOCK)
			|| (op_q == lsch_pkg::OP_EXIT);
		sts.ignore = (op_q > lsch_pkg::OP_EXIT)
			|| (((op_q == lsch_pkg::OP_BLOCK) || (op_q == lsch_pkg::OP_EXIT)) && run_idle_q)
			|| (!sts.is_sched && !slot_ok_q);
		sts.is_block = (op_q == lsch_pkg::OP_BLOCK);
		if (op_q == lsch_pkg::OP_TICK)
			sts.need_raffle = run_idle_q ? (pool_q != '0) : (qinc >= quantum_q);
		else
			sts.need_raffle = 1'b1;
		sts.div_done  = div_done;
		sts.walk_done = found_q || (widx_q == CNT_W'(MAX_TASKS));
		sts.pool_zero = (pool_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q  <= 8'd10;
			lfsr_q     <= 32'd1;
			valid_q    <= '0;
			blocked_q  <= '0;
			pool_q     <= '0;
			qcount_q   <= '0;
			run_q      <= '0;
			run_idle_q <= 1'b1;
			out_v_q    <= 1'b0;
			found_q    <= 1'b0;
			widx_q     <= '0;
		end else begin
			out_v_q <= cmd.emit;
			if (cfg_we) begin
				if (cfg_idx == lsch_pkg::CFG_QUANTUM)
					quantum_q <= cfg_data[7:0];
				else
					lfsr_q <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
			end
			if (cmd.do_event) begin
				unique case (op_q)
					lsch_pkg::OP_LOAD: begin
						if (!valid_q[sidx_q]) begin
							valid_q[sidx_q]   <= 1'b1;
							blocked_q[sidx_q] <= 1'b0;
							pool_q <= pool_q + PW'(1);
						end
					end
					lsch_pkg::OP_UNBLOCK: begin
						if (valid_q[sidx_q] && blocked_q[sidx_q]) begin
							blocked_q[sidx_q] <= 1'b0;
							pool_q <= pool_q + PW'(sel_t);
						end
					end
					lsch_pkg::OP_TICK: begin
						qcount_q <= sts.need_raffle ? 8'd0 : qinc;
					end
					lsch_pkg::OP_EXIT: begin
						qcount_q <= '0;
						pool_q <= (pool_q >= PW'(cur_t)) ? pool_q - PW'(cur_t) : '0;
						valid_q[run_q]   <= 1'b0;
						blocked_q[run_q] <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.do_block) begin
				qcount_q <= '0;
				blocked_q[run_q] <= 1'b1;
				pool_q <= (pool_q >= PW'(cur_t)) ? pool_q - PW'(cur_t) : '0;
			end
			if (cmd.raffle_start) begin
				if (pool_q == '0) begin
					run_idle_q <= 1'b1;
					run_q <= '0;
				end else begin
					lfsr_q <= lfsr_next;
				end
			end
			if (cmd.walk_start) begin
				widx_q  <= '0;
				found_q <= 1'b0;
			end else if (cmd.walk_step) begin
				if (widx_q == CNT_W'(MAX_TASKS)) begin
					run_idle_q <= 1'b1;
					run_q <= '0;
				end else if (!found_q) begin
					if (valid_q[widx] && !blocked_q[widx] && acc_n >= {1'b0, draw_q}) begin
						found_q    <= 1'b1;
						run_idle_q <= 1'b0;
						run_q      <= widx;
					end else begin
						widx_q <= widx_q + 1'b1;
					end
				end
			end
		end
	end

	assign tsum = {1'b0, cur_t} + {1'b0, TICKET_BITS'(div_q)};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			slot_ok_q <= (32'(task_slot) < MAX_TASKS);
			sidx_q <= SW'(task_slot);
		end
		if (cmd.do_event) begin
			if (op_q == lsch_pkg::OP_LOAD && !valid_q[sidx_q])
				tickets_q[sidx_q] <= TICKET_BITS'(1);
			if (op_q == lsch_pkg::OP_EXIT)
				tickets_q[run_q] <= '0;
		end
		if (cmd.do_block) begin
			if (qinc < quantum_q) begin
				if ((div_q[31:TICKET_BITS] != '0) || tsum[TICKET_BITS])
					tickets_q[run_q] <= CAP;
				else
					tickets_q[run_q] <= tsum[TICKET_BITS-1:0];
			end
		end
		if (cmd.walk_start) begin
			draw_q <= PW'(div_r) + PW'(1);
			acc_q  <= '0;
		end else if (cmd.walk_step && !found_q && widx_q != CNT_W'(MAX_TASKS)) begin
			if (valid_q[widx] && !blocked_q[widx])
				acc_q <= acc_n[PW-1:0];
		end
	end

	assign valid     = out_v_q;
	assign next_task = run_idle_q ? 4'd0 : 4'(run_q);
	assign idle      = run_idle_q;

endmodule
`default_nettype wire
